// File: hdl/compass_response_frame_parser_assert.svh
// assertion helpers shared by the checker
`ifndef COMPASS_RESPONSE_FRAME_PARSER_ASSERT_SVH
`define COMPASS_RESPONSE_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, quiet while reset is held
`define CRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define CRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/crp_pkg.sv
`timescale 1ns / 1ps
package crp_pkg;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_INFO    = 2'd1,
    KIND_UNKNOWN = 2'd2,
    KIND_SHORT   = 2'd3
  } kind_t;

  localparam logic [2:0] CFG_DATA_ID    = 3'd0;
  localparam logic [2:0] CFG_INFO_ID    = 3'd1;
  localparam logic [2:0] CFG_HEAD_CODE  = 3'd2;
  localparam logic [2:0] CFG_PITCH_CODE = 3'd3;
  localparam logic [2:0] CFG_ROLL_CODE  = 3'd4;

  localparam logic [7:0] DATA_ID_RST    = 8'd5;
  localparam logic [7:0] INFO_ID_RST    = 8'd2;
  localparam logic [7:0] HEAD_CODE_RST  = 8'd5;
  localparam logic [7:0] PITCH_CODE_RST = 8'd24;
  localparam logic [7:0] ROLL_CODE_RST  = 8'd25;

  localparam logic [15:0] MIN_FRAME_LEN = 16'd5;
  localparam logic [15:0] HDR_BYTES     = 16'd3;
  localparam logic [15:0] INFO_BYTES    = 16'd8;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [2:0]  LAST_PHASE    = 3'd4;

  // payload word handed from the frame sequencer to the payload unit
  typedef struct packed {
    logic        frame_start;
    logic        pay_en;
    logic [15:0] offset;
    logic [7:0]  data;
    logic        is_data;
    logic        is_info;
  } pay_t;

  // end-of-frame report
  typedef struct packed {
    logic  emit;
    kind_t kind;
    logic  crc_ok;
  } evt_t;

endpackage

// File: hdl/compass_response_frame_parser.sv
`timescale 1ns / 1ps
// Compass response frame parser.
// in_*  : one received byte per word (in_rx_byte), valid/ready.
// out_* : one result word per frame, given at the last checksum byte, or at the
//         second length byte when the length is below five (kind short).
//         Words carry the kept heading/pitch/roll, their update flags for this
//         frame, the module type/revision and the checksum verdict.
// cfg_* : register writes (cfg_index, cfg_data), always ready; write only while
//         the parser is idle. Unknown indexes are ignored.
// A byte taken is held in the input register until it advances; a result it causes
// is then registered in the result register and shown on out_* from there.
// Throughput: one byte per cycle while no result is held stalled; the byte-wise crc
// update and the entry decode both settle in the single stage after the input register.
// When the receiver stalls with a result held, the input register still takes
// one byte; further bytes wait until the result is taken.
// Reset (rst_n low, synchronous) clears all stores and flags, returns the
// frame position to the first length byte and restores the register defaults.
module compass_response_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_frame_kind,
  output logic [31:0] out_heading_word,
  output logic [31:0] out_pitch_word,
  output logic [31:0] out_roll_word,
  output logic        out_heading_new,
  output logic        out_pitch_new,
  output logic        out_roll_new,
  output logic [31:0] out_module_type,
  output logic [31:0] out_module_revision,
  output logic        out_crc_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        advance;

  logic [7:0]  data_id_r;
  logic [7:0]  info_id_r;
  logic [7:0]  head_code_r;
  logic [7:0]  pitch_code_r;
  logic [7:0]  roll_code_r;

  crp_pkg::pay_t pay;
  crp_pkg::evt_t evt;

  logic [31:0] heading;
  logic [31:0] pitch;
  logic [31:0] roll;
  logic [31:0] mod_type;
  logic [31:0] mod_rev;
  logic [2:0]  marks;

  logic        out_valid_r;
  logic [1:0]  kind_r;
  logic [31:0] head_out_r;
  logic [31:0] pitch_out_r;
  logic [31:0] roll_out_r;
  logic [2:0]  marks_out_r;
  logic [31:0] type_out_r;
  logic [31:0] rev_out_r;
  logic        crc_ok_r;

  // a byte moves on when the result register is free or being emptied
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_id_r    <= crp_pkg::DATA_ID_RST;
      info_id_r    <= crp_pkg::INFO_ID_RST;
      head_code_r  <= crp_pkg::HEAD_CODE_RST;
      pitch_code_r <= crp_pkg::PITCH_CODE_RST;
      roll_code_r  <= crp_pkg::ROLL_CODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        crp_pkg::CFG_DATA_ID:    data_id_r    <= cfg_data;
        crp_pkg::CFG_INFO_ID:    info_id_r    <= cfg_data;
        crp_pkg::CFG_HEAD_CODE:  head_code_r  <= cfg_data;
        crp_pkg::CFG_PITCH_CODE: pitch_code_r <= cfg_data;
        crp_pkg::CFG_ROLL_CODE:  roll_code_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  crp_frame_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_b    (in_byte_r),
    .data_id (data_id_r),
    .info_id (info_id_r),
    .pay     (pay),
    .evt     (evt)
  );

  crp_payload u_payload (
    .clk        (clk),
    .rst_n      (rst_n),
    .pay        (pay),
    .head_code  (head_code_r),
    .pitch_code (pitch_code_r),
    .roll_code  (roll_code_r),
    .heading    (heading),
    .pitch      (pitch),
    .roll       (roll),
    .mod_type   (mod_type),
    .mod_rev    (mod_rev),
    .marks      (marks)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (evt.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // stores are not touched by the byte that closes a frame
  always_ff @(posedge clk) begin
    if (evt.emit) begin
      kind_r      <= evt.kind;
      crc_ok_r    <= evt.crc_ok;
      head_out_r  <= heading;
      pitch_out_r <= pitch;
      roll_out_r  <= roll;
      marks_out_r <= marks;
      type_out_r  <= mod_type;
      rev_out_r   <= mod_rev;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_kind      = kind_r;
  assign out_heading_word    = head_out_r;
  assign out_pitch_word      = pitch_out_r;
  assign out_roll_word       = roll_out_r;
  assign out_heading_new     = marks_out_r[0];
  assign out_pitch_new       = marks_out_r[1];
  assign out_roll_new        = marks_out_r[2];
  assign out_module_type     = type_out_r;
  assign out_module_revision = rev_out_r;
  assign out_crc_ok          = crc_ok_r;

endmodule

// File: hdl/crp_crc16.sv
`timescale 1ns / 1ps
module crp_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  logic [15:0] c;

  // msb-first, one bit per step
  always_comb begin
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ crp_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// File: hdl/crp_frame_seq.sv
`timescale 1ns / 1ps
module crp_frame_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_b,
  input  logic [7:0]        data_id,
  input  logic [7:0]        info_id,
  output crp_pkg::pay_t     pay,
  output crp_pkg::evt_t     evt
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  ident_r, ident_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  chk_hi_r, chk_hi_nxt;

  logic [15:0] crc_seed;
  logic [15:0] crc_upd;
  logic [16:0] pos_plus2;
  logic [16:0] len_ext;
  logic [15:0] full_len;
  logic        is_data;
  logic        is_info;

  assign crc_seed  = (pos_r == 16'd0) ? 16'd0 : crc_r;
  assign pos_plus2 = {1'b0, pos_r} + 17'd2;
  assign len_ext   = {1'b0, len_r};
  assign full_len  = {len_r[15:8], rx_b};
  assign is_data   = (ident_r == data_id);
  assign is_info   = !is_data && (ident_r == info_id);

  crp_crc16 u_crc (
    .crc_in  (crc_seed),
    .data_in (rx_b),
    .crc_out (crc_upd)
  );

  always_comb begin
    pos_nxt          = pos_r;
    len_nxt          = len_r;
    ident_nxt        = ident_r;
    crc_nxt          = crc_r;
    chk_hi_nxt       = chk_hi_r;
    pay.frame_start  = 1'b0;
    pay.pay_en       = 1'b0;
    pay.offset       = pos_r - crp_pkg::HDR_BYTES;
    pay.data         = rx_b;
    pay.is_data      = is_data;
    pay.is_info      = is_info;
    evt.emit         = 1'b0;
    evt.kind         = crp_pkg::KIND_SHORT;
    evt.crc_ok       = 1'b0;
    if (step) begin
      priority if (pos_r == 16'd0) begin
        crc_nxt         = crc_upd;
        len_nxt         = {rx_b, 8'h00};
        pos_nxt         = 16'd1;
        pay.frame_start = 1'b1;
      end else if (pos_r == 16'd1) begin
        crc_nxt = crc_upd;
        len_nxt = full_len;
        if (full_len < crp_pkg::MIN_FRAME_LEN) begin
          pos_nxt  = 16'd0;
          evt.emit = 1'b1;
        end else begin
          pos_nxt = 16'd2;
        end
      end else if (pos_r == 16'd2) begin
        crc_nxt   = crc_upd;
        ident_nxt = rx_b;
        pos_nxt   = 16'd3;
      end else if (pos_plus2 < len_ext) begin
        crc_nxt    = crc_upd;
        pay.pay_en = 1'b1;
        pos_nxt    = pos_r + 16'd1;
      end else if (pos_plus2 == len_ext) begin
        chk_hi_nxt = rx_b;
        pos_nxt    = pos_r + 16'd1;
      end else begin
        pos_nxt    = 16'd0;
        evt.emit   = 1'b1;
        evt.crc_ok = ({chk_hi_r, rx_b} == crc_r);
        priority if (is_data) begin
          evt.kind = crp_pkg::KIND_DATA;
        end else if (is_info) begin
          evt.kind = crp_pkg::KIND_INFO;
        end else begin
          evt.kind = crp_pkg::KIND_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      len_r    <= '0;
      ident_r  <= '0;
      crc_r    <= '0;
      chk_hi_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      len_r    <= len_nxt;
      ident_r  <= ident_nxt;
      crc_r    <= crc_nxt;
      chk_hi_r <= chk_hi_nxt;
    end
  end

endmodule

// File: hdl/crp_payload.sv
`timescale 1ns / 1ps
module crp_payload (
  input  logic          clk,
  input  logic          rst_n,
  input  crp_pkg::pay_t pay,
  input  logic [7:0]    head_code,
  input  logic [7:0]    pitch_code,
  input  logic [7:0]    roll_code,
  output logic [31:0]   heading,
  output logic [31:0]   pitch,
  output logic [31:0]   roll,
  output logic [31:0]   mod_type,
  output logic [31:0]   mod_rev,
  output logic [2:0]    marks
);

  logic [7:0]  total_r, total_nxt;
  logic [7:0]  done_r, done_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [23:0] shift_r, shift_nxt;
  logic [31:0] head_r, head_nxt;
  logic [31:0] pitch_r, pitch_nxt;
  logic [31:0] roll_r, roll_nxt;
  logic [31:0] type_r, type_nxt;
  logic [31:0] rev_r, rev_nxt;
  logic [2:0]  marks_r, marks_nxt;

  logic [31:0] value;
  logic [4:0]  lane_lsb;

  assign value    = {shift_r, pay.data};
  // first byte of each group lands in the top byte
  assign lane_lsb = {~pay.offset[1:0], 3'b000};

  always_comb begin
    total_nxt = total_r;
    done_nxt  = done_r;
    phase_nxt = phase_r;
    code_nxt  = code_r;
    shift_nxt = shift_r;
    head_nxt  = head_r;
    pitch_nxt = pitch_r;
    roll_nxt  = roll_r;
    type_nxt  = type_r;
    rev_nxt   = rev_r;
    marks_nxt = pay.frame_start ? 3'b000 : marks_r;
    if (pay.pay_en && pay.is_data) begin
      priority if (pay.offset == 16'd0) begin
        total_nxt = pay.data;
        done_nxt  = '0;
        phase_nxt = '0;
      end else if (phase_r == 3'd0) begin
        code_nxt  = pay.data;
        shift_nxt = '0;
        phase_nxt = 3'd1;
      end else begin
        shift_nxt = value[23:0];
        if (phase_r >= crp_pkg::LAST_PHASE) begin
          phase_nxt = '0;
          if (done_r < total_r) begin
            if (code_r == head_code) begin
              head_nxt     = value;
              marks_nxt[0] = 1'b1;
            end
            if (code_r == pitch_code) begin
              pitch_nxt    = value;
              marks_nxt[1] = 1'b1;
            end
            if (code_r == roll_code) begin
              roll_nxt     = value;
              marks_nxt[2] = 1'b1;
            end
            done_nxt = done_r + 8'd1;
          end
        end else begin
          phase_nxt = phase_r + 3'd1;
        end
      end
    end else if (pay.pay_en && pay.is_info && (pay.offset < crp_pkg::INFO_BYTES)) begin
      if (pay.offset[2]) begin
        rev_nxt[lane_lsb +: 8] = pay.data;
      end else begin
        type_nxt[lane_lsb +: 8] = pay.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      done_r  <= '0;
      phase_r <= '0;
      code_r  <= '0;
      shift_r <= '0;
      head_r  <= '0;
      pitch_r <= '0;
      roll_r  <= '0;
      type_r  <= '0;
      rev_r   <= '0;
      marks_r <= '0;
    end else begin
      total_r <= total_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
      shift_r <= shift_nxt;
      head_r  <= head_nxt;
      pitch_r <= pitch_nxt;
      roll_r  <= roll_nxt;
      type_r  <= type_nxt;
      rev_r   <= rev_nxt;
      marks_r <= marks_nxt;
    end
  end

  assign heading  = head_r;
  assign pitch    = pitch_r;
  assign roll     = roll_r;
  assign mod_type = type_r;
  assign mod_rev  = rev_r;
  assign marks    = marks_r;

endmodule

// File: hdl/crp_port_checker.sv
`timescale 1ns / 1ps
`include "compass_response_frame_parser_assert.svh"
module crp_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_frame_kind,
  input logic [31:0] out_heading_word,
  input logic        out_heading_new,
  input logic        out_pitch_new,
  input logic        out_roll_new,
  input logic        out_crc_ok
);

  `CRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  `CRP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_heading_word), "stalled heading changed")

  `CRP_ASSERT_NOW(a_short_clean, out_valid && (out_frame_kind == crp_pkg::KIND_SHORT), !out_heading_new && !out_pitch_new && !out_roll_new && !out_crc_ok, "short frame reported updates or good crc")

  `CRP_ASSERT_NOW(a_info_no_marks, out_valid && (out_frame_kind == crp_pkg::KIND_INFO), !out_heading_new && !out_pitch_new && !out_roll_new, "info frame flagged an angle update")

endmodule

bind compass_response_frame_parser crp_port_checker u_port_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_kind   (out_frame_kind),
  .out_heading_word (out_heading_word),
  .out_heading_new  (out_heading_new),
  .out_pitch_new    (out_pitch_new),
  .out_roll_new     (out_roll_new),
  .out_crc_ok       (out_crc_ok)
);

// File: tb/tb_compass_response_frame_parser.sv
`timescale 1ns / 1ps
module tb_compass_response_frame_parser;

  // index with no register behind it, writes must be ignored
  localparam logic [2:0] CFG_SPARE = 3'd7;

  typedef logic [7:0] byte_list_t[$];

  typedef struct packed {
    crp_pkg::kind_t kind;
    logic [31:0] heading;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [2:0]  fresh;
    logic [31:0] mod_type;
    logic [31:0] mod_rev;
    logic        crc_ok;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_frame_kind;
  logic [31:0] out_heading_word;
  logic [31:0] out_pitch_word;
  logic [31:0] out_roll_word;
  logic        out_heading_new;
  logic        out_pitch_new;
  logic        out_roll_new;
  logic [31:0] out_module_type;
  logic [31:0] out_module_revision;
  logic        out_crc_ok;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'h00;

  compass_response_frame_parser dut (.*);

  // register copies
  logic [7:0] reg_data_id = crp_pkg::DATA_ID_RST;
  logic [7:0] reg_info_id = crp_pkg::INFO_ID_RST;
  logic [7:0] reg_head_code = crp_pkg::HEAD_CODE_RST;
  logic [7:0] reg_pitch_code = crp_pkg::PITCH_CODE_RST;
  logic [7:0] reg_roll_code = crp_pkg::ROLL_CODE_RST;

  // parser state as predicted
  logic [15:0] fr_pos = '0;
  logic [15:0] fr_len = '0;
  logic [7:0]  fr_ident = '0;
  logic [7:0]  ent_total = '0;
  logic [7:0]  ent_done = '0;
  logic [2:0]  ent_phase = '0;
  logic [7:0]  ent_code = '0;
  logic [31:0] ent_value = '0;
  logic [31:0] heading_st = '0;
  logic [31:0] pitch_st = '0;
  logic [31:0] roll_st = '0;
  logic [31:0] type_st = '0;
  logic [31:0] rev_st = '0;
  logic [15:0] crc_run = '0;
  logic [15:0] crc_rx = '0;
  logic [2:0]  fresh = '0;

  logic [7:0]    byte_q[$];
  frame_report_t reports_q[$];
  int unsigned   mismatches = 0;
  int unsigned   pushed_bytes = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  logic          steady = 1'b0;
  int            steady_left = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) r = r[15] ? ((r << 1) ^ crp_pkg::CRC_POLY) : (r << 1);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void post_report(input crp_pkg::kind_t k, input logic ok);
    frame_report_t rep;
    rep.kind = k;
    rep.heading = heading_st;
    rep.pitch = pitch_st;
    rep.roll = roll_st;
    rep.fresh = fresh;
    rep.mod_type = type_st;
    rep.mod_rev = rev_st;
    rep.crc_ok = ok;
    reports_q.push_back(rep);
  endfunction

  function void apply_payload(input logic [15:0] off, input logic [7:0] b);
    if (fr_ident == reg_data_id) begin
      if (off == 16'd0) begin
        ent_total = b;
        ent_done = '0;
        ent_phase = '0;
      end else if (ent_phase == 3'd0) begin
        ent_code = b;
        ent_value = '0;
        ent_phase = 3'd1;
      end else begin
        ent_value = {ent_value[23:0], b};
        if (ent_phase >= crp_pkg::LAST_PHASE) begin
          // entries past the announced count are skipped
          if (ent_done < ent_total) begin
            if (ent_code == reg_head_code) begin
              heading_st = ent_value;
              fresh[0] = 1'b1;
            end
            if (ent_code == reg_pitch_code) begin
              pitch_st = ent_value;
              fresh[1] = 1'b1;
            end
            if (ent_code == reg_roll_code) begin
              roll_st = ent_value;
              fresh[2] = 1'b1;
            end
            ent_done++;
          end
          ent_phase = 3'd0;
        end else begin
          ent_phase++;
        end
      end
    end else if (fr_ident == reg_info_id) begin
      if (off < crp_pkg::INFO_BYTES) begin
        if (off < 16'd4) type_st[8 * (3 - off[1:0]) +: 8] = b;
        else rev_st[8 * (3 - off[1:0]) +: 8] = b;
      end
    end
  endfunction

  function void parse_byte(input logic [7:0] b);
    crp_pkg::kind_t k;
    if (fr_pos == 16'd0) begin
      crc_run = crc_step(16'h0000, b);
      fresh = '0;
      ent_total = '0;
      ent_done = '0;
      ent_phase = '0;
      ent_code = '0;
      ent_value = '0;
      crc_rx = '0;
      fr_len = {b, 8'h00};
      fr_pos = 16'd1;
    end else if (fr_pos == 16'd1) begin
      crc_run = crc_step(crc_run, b);
      fr_len[7:0] = b;
      if (fr_len < crp_pkg::MIN_FRAME_LEN) begin
        fr_pos = 16'd0;
        post_report(crp_pkg::KIND_SHORT, 1'b0);
      end else begin
        fr_pos = 16'd2;
      end
    end else if (fr_pos == 16'd2) begin
      crc_run = crc_step(crc_run, b);
      fr_ident = b;
      fr_pos = 16'd3;
    end else if (32'(fr_pos) + 2 < 32'(fr_len)) begin
      crc_run = crc_step(crc_run, b);
      apply_payload(fr_pos - crp_pkg::HDR_BYTES, b);
      fr_pos++;
    end else if (32'(fr_pos) + 2 == 32'(fr_len)) begin
      crc_rx = {b, 8'h00};
      fr_pos++;
    end else begin
      crc_rx[7:0] = b;
      fr_pos = 16'd0;
      if (fr_ident == reg_data_id) k = crp_pkg::KIND_DATA;
      else if (fr_ident == reg_info_id) k = crp_pkg::KIND_INFO;
      else k = crp_pkg::KIND_UNKNOWN;
      post_report(k, crc_rx == crc_run);
    end
  endfunction

  function void check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (fire) void'(byte_q.pop_front());
      if (in_valid && !fire) begin
        // word held until taken
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (byte_q.size() > 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= byte_q[0];
        send_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: results checked before the byte of this edge is predicted
  always @(posedge clk) begin
    frame_report_t want;
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_q.size() == 0) begin
          $error("result word with nothing expected");
          mismatches++;
        end else begin
          want = reports_q.pop_front();
          check_field("frame_kind", 32'(want.kind), 32'(out_frame_kind));
          check_field("heading_word", want.heading, out_heading_word);
          check_field("pitch_word", want.pitch, out_pitch_word);
          check_field("roll_word", want.roll, out_roll_word);
          check_field("heading_new", 32'(want.fresh[0]), 32'(out_heading_new));
          check_field("pitch_new", 32'(want.fresh[1]), 32'(out_pitch_new));
          check_field("roll_new", 32'(want.fresh[2]), 32'(out_roll_new));
          check_field("module_type", want.mod_type, out_module_type);
          check_field("module_revision", want.mod_rev, out_module_revision);
          check_field("crc_ok", 32'(want.crc_ok), 32'(out_crc_ok));
        end
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        gap = pick_gap();
        stall_left <= gap;
        out_ready <= (gap == 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= steady || ($urandom_range(0, 9) != 0);
      end
    end
  end

  // stretches without any idling
  always @(posedge clk) begin
    if (steady_left == 0) begin
      steady <= ($urandom_range(0, 3) == 0);
      steady_left <= $urandom_range(50, 300);
    end else begin
      steady_left <= steady_left - 1;
    end
  end

  function automatic byte_list_t entry_of(input logic [7:0] c, input logic [31:0] v);
    return '{c, v[31:24], v[23:16], v[15:8], v[7:0]};
  endfunction

  function automatic byte_list_t noise(input int n);
    byte_list_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  function automatic void push_frame(input logic [7:0] id, input byte_list_t body,
                                     input bit bad_crc);
    logic [15:0] len;
    logic [15:0] crc;
    byte_list_t  q;
    len = 16'(body.size()) + crp_pkg::MIN_FRAME_LEN;
    q = {len[15:8], len[7:0], id, body};
    crc = 16'h0000;
    foreach (q[i]) crc = crc_step(crc, q[i]);
    if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    q.push_back(crc[15:8]);
    q.push_back(crc[7:0]);
    foreach (q[i]) byte_q.push_back(q[i]);
    pushed_bytes += q.size();
  endfunction

  function automatic void push_short(input logic [15:0] len);
    byte_q.push_back(len[15:8]);
    byte_q.push_back(len[7:0]);
    pushed_bytes += 2;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 3))
      0: return reg_head_code;
      1: return reg_pitch_code;
      2: return reg_roll_code;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] other_id();
    logic [7:0] id;
    do id = 8'($urandom); while (id == reg_data_id || id == reg_info_id);
    return id;
  endfunction

  function automatic void push_random_frame();
    byte_list_t body;
    int         sel;
    int         n;
    bit         bad;
    sel = $urandom_range(0, 99);
    bad = ($urandom_range(0, 9) == 0);
    if (sel < 10) begin
      push_short(16'($urandom_range(0, 4)));
    end else if (sel < 55) begin
      n = $urandom_range(0, 5);
      body.push_back(8'(n));
      repeat (n) body = {body, entry_of(pick_code(), pick_word())};
      push_frame(reg_data_id, body, bad);
    end else if (sel < 70) begin
      // count drawn apart from the entries, ragged tail
      body.push_back(8'($urandom_range(0, 6)));
      repeat ($urandom_range(0, 4)) body = {body, entry_of(pick_code(), pick_word())};
      body = {body, noise($urandom_range(0, 4))};
      push_frame(reg_data_id, body, bad);
    end else if (sel < 85) begin
      n = ($urandom_range(0, 1) == 0) ? 8 : $urandom_range(0, 11);
      push_frame(reg_info_id, noise(n), bad);
    end else if (sel < 97) begin
      push_frame(other_id(), noise($urandom_range(0, 12)), bad);
    end else begin
      case ($urandom_range(0, 2))
        0: push_frame(reg_data_id, noise($urandom_range(13, 40)), bad);
        1: push_frame(reg_info_id, noise($urandom_range(13, 40)), bad);
        default: push_frame(other_id(), noise($urandom_range(13, 40)), bad);
      endcase
    end
  endfunction

  task automatic random_chunk(input int min_bytes, input int min_frames);
    int start_bytes;
    int frames;
    start_bytes = pushed_bytes;
    frames = 0;
    while (pushed_bytes - start_bytes < min_bytes || frames < min_frames) begin
      push_random_frame();
      frames++;
    end
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || reports_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      crp_pkg::CFG_DATA_ID:    reg_data_id = val;
      crp_pkg::CFG_INFO_ID:    reg_info_id = val;
      crp_pkg::CFG_HEAD_CODE:  reg_head_code = val;
      crp_pkg::CFG_PITCH_CODE: reg_pitch_code = val;
      crp_pkg::CFG_ROLL_CODE:  reg_roll_code = val;
      default: ;
    endcase
  endtask

  initial begin
    byte_list_t none;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset
    push_short(16'h0000);
    push_short(16'h0004);
    push_frame(reg_data_id, none, 0);
    push_frame(reg_data_id, {8'd3, entry_of(reg_head_code, 32'hFFFF_FFFF),
                             entry_of(reg_pitch_code, 32'h0000_0000),
                             entry_of(reg_roll_code, 32'h8000_0001)}, 0);
    push_frame(reg_info_id, {8'h43, 8'h4F, 8'h4D, 8'h50, 8'h31, 8'h2E, 8'h30, 8'h37}, 0);
    push_frame(reg_info_id, {8'hFF, 8'h00, 8'hA5}, 0);
    push_frame(reg_info_id, noise(12), 0);
    push_frame(reg_data_id, {8'd1, entry_of(reg_head_code, 32'h1234_5678),
                             entry_of(reg_head_code, 32'h9ABC_DEF0)}, 0);
    push_frame(reg_data_id, {8'd2, entry_of(reg_pitch_code, 32'h3F80_0000),
                             8'h18, 8'hAA, 8'h55}, 0);
    push_frame(reg_data_id, {8'd2, entry_of(reg_roll_code, 32'h0F0F_0F0F),
                             entry_of(reg_roll_code, 32'hF0F0_F0F0)}, 0);
    push_frame(8'hFF, {8'hFF, 8'hFF, 8'hFF, 8'hFF}, 0);
    push_frame(reg_data_id, {8'd1, entry_of(reg_pitch_code, 32'hC2C8_0000)}, 1);
    push_frame(reg_data_id, {8'hFF, entry_of(reg_head_code, 32'h4000_0000)}, 0);
    // length just past one byte's range
    push_frame(8'h77, noise(16'h00FC), 0);
    random_chunk(30, 3);
    settle();

    // extreme settings, equal heading and roll codes
    write_reg(crp_pkg::CFG_DATA_ID, 8'h00);
    write_reg(crp_pkg::CFG_INFO_ID, 8'hFF);
    write_reg(crp_pkg::CFG_HEAD_CODE, 8'h00);
    write_reg(crp_pkg::CFG_PITCH_CODE, 8'hFF);
    write_reg(crp_pkg::CFG_ROLL_CODE, 8'h00);
    @(negedge clk);
    push_frame(reg_data_id, {8'd2, entry_of(8'h00, 32'hDEAD_BEEF),
                             entry_of(8'hFF, 32'h0000_00FF)}, 0);
    push_frame(reg_info_id, noise(8), 0);
    push_frame(8'h05, noise(6), 0);
    random_chunk(12, 1);
    settle();

    // both ids equal, all codes equal
    write_reg(crp_pkg::CFG_DATA_ID, 8'h3C);
    write_reg(crp_pkg::CFG_INFO_ID, 8'h3C);
    write_reg(crp_pkg::CFG_HEAD_CODE, 8'h07);
    write_reg(crp_pkg::CFG_PITCH_CODE, 8'h07);
    write_reg(crp_pkg::CFG_ROLL_CODE, 8'h07);
    @(negedge clk);
    push_frame(8'h3C, {8'd1, entry_of(8'h07, 32'h5555_AAAA)}, 0);
    random_chunk(12, 1);
    settle();

    write_reg(crp_pkg::CFG_DATA_ID, 8'($urandom));
    write_reg(crp_pkg::CFG_INFO_ID, 8'($urandom));
    write_reg(crp_pkg::CFG_HEAD_CODE, 8'($urandom));
    write_reg(crp_pkg::CFG_PITCH_CODE, 8'($urandom));
    write_reg(crp_pkg::CFG_ROLL_CODE, 8'($urandom));
    write_reg(CFG_SPARE, 8'($urandom));
    @(negedge clk);
    random_chunk(12, 1);
    settle();

    // back to the defaults
    write_reg(crp_pkg::CFG_DATA_ID, crp_pkg::DATA_ID_RST);
    write_reg(crp_pkg::CFG_INFO_ID, crp_pkg::INFO_ID_RST);
    write_reg(crp_pkg::CFG_HEAD_CODE, crp_pkg::HEAD_CODE_RST);
    write_reg(crp_pkg::CFG_PITCH_CODE, crp_pkg::PITCH_CODE_RST);
    write_reg(crp_pkg::CFG_ROLL_CODE, crp_pkg::ROLL_CODE_RST);
    @(negedge clk);
    random_chunk(12, 1);
    settle();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: compass_response_frame_parser.f
+incdir+hdl
hdl/crp_pkg.sv
hdl/crp_crc16.sv
hdl/crp_frame_seq.sv
hdl/crp_payload.sv
hdl/compass_response_frame_parser.sv
hdl/crp_port_checker.sv
tb/tb_compass_response_frame_parser.sv
